[hw/rtl/tscr_pkg.sv]
// Shared types and codes for the text screen cursor engine.
package tscr_pkg;

   // Item opcodes
   localparam logic [4:0] OP_PUT        = 5'd0;
   localparam logic [4:0] OP_NEWLINE    = 5'd1;
   localparam logic [4:0] OP_TAB        = 5'd2;
   localparam logic [4:0] OP_SETTAB     = 5'd3;
   localparam logic [4:0] OP_CLRTAB     = 5'd4;
   localparam logic [4:0] OP_CLRALLTABS = 5'd5;
   localparam logic [4:0] OP_DOWN       = 5'd6;
   localparam logic [4:0] OP_UP         = 5'd7;
   localparam logic [4:0] OP_MOVEREL    = 5'd8;
   localparam logic [4:0] OP_SETPOS     = 5'd9;
   localparam logic [4:0] OP_SCROLLFWD  = 5'd10;
   localparam logic [4:0] OP_SCROLLBACK = 5'd11;
   localparam logic [4:0] OP_FILL       = 5'd12;
   localparam logic [4:0] OP_CLEAR      = 5'd13;
   localparam logic [4:0] OP_ERASE_SOS  = 5'd14;
   localparam logic [4:0] OP_ERASE_EOS  = 5'd15;
   localparam logic [4:0] OP_ERASE_SOL  = 5'd16;
   localparam logic [4:0] OP_ERASE_EOL  = 5'd17;
   localparam logic [4:0] OP_ERASE_LINE = 5'd18;
   localparam logic [4:0] OP_READ       = 5'd19;
   localparam logic [4:0] OP_DEFTABS    = 5'd20;

   // Register indexes on the control port
   localparam logic [1:0] REG_TOP_MARGIN    = 2'd0;
   localparam logic [1:0] REG_BOTTOM_MARGIN = 2'd1;
   localparam logic [1:0] REG_ORIGIN        = 2'd2;
   localparam logic [1:0] REG_FORCED_ATTR   = 2'd3;

   localparam logic [15:0] BLANK_CELL = 16'h0F20;
   localparam logic [7:0]  FILL_ATTR  = 8'h0F;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PREP,
      ST_EXEC,
      ST_CP_RD,
      ST_CP_WR,
      ST_BLANK,
      ST_TAB_SWEEP,
      ST_TAB_RD,
      ST_TAB_CHK,
      ST_RD_ISSUE,
      ST_RD_TAKE,
      ST_PUT_WR,
      ST_DONE
   } state_type;

   // What follows a blanking sweep
   typedef enum logic [1:0] {
      AFT_DONE,
      AFT_PUT,
      AFT_HOME
   } after_type;

endpackage

[hw/rtl/text_screen_cursor_engine.sv]
// Top level of the text screen cursor engine: cell store, tab stops and cursor sequencer.
//
//   Channel  Direction  Handshake          Word
//   req_     in         req_valid/stall    opcode, char, attribute, column and row arguments
//   rsp_     out        rsp_valid/stall    cursor column, cursor row, pending wrap, read cell
//   csr_     in/out     APB style          top, bottom, origin mode, forced attribute
//
// After reset the block writes blank cells and default tab stops over the whole screen,
// one cell a cycle; it accepts no word in that time, but register writes are taken.
// A word is accepted in the idle state and passes through the preparation and execute
// states, any sweep it needs and the done state. A tab reads and checks one column at a time.
// Scrolls copy the region through the cell store, reading and then writing each cell, and
// then blank one row; fills, erases and tab sweeps write one cell a cycle.
// The finished word sits in the output register; while it is held there by a stall the
// block accepts no new word, and it can accept one in the same cycle that the result is taken.
module text_screen_cursor_engine
   import tscr_pkg::*;
#(
   parameter int COLS        = 80,
   parameter int ROWS        = 25,
   parameter int TAB_SPACING = 6
) (
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_stall,
   input  logic [4:0]        req_opcode,
   input  logic [7:0]        req_char_code,
   input  logic [7:0]        req_attr_byte,
   input  logic signed [7:0] req_col_arg,
   input  logic signed [7:0] req_row_arg,

   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [6:0]        rsp_cursor_col,
   output logic [4:0]        rsp_cursor_row,
   output logic              rsp_pending_wrap,
   output logic [15:0]       rsp_read_cell,

   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [3:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int CELLS = ROWS * COLS;
   localparam int IW    = $clog2(CELLS);
   localparam int AW    = $clog2(CELLS + COLS + 1);
   localparam int CW    = $clog2(COLS + 1);
   localparam int RW    = $clog2(ROWS);
   localparam int TW    = $clog2(TAB_SPACING + 1);

   // Control registers
   logic [4:0] top_ff, top_in;
   logic [4:0] bot_ff, bot_in;
   logic       origin_ff, origin_in;
   logic [7:0] forced_ff, forced_in;

   // Sequencer and latched word
   state_type         state_ff, state_in;
   after_type         aft_ff, aft_in;
   logic [4:0]        op_ff, op_in;
   logic [7:0]        ch_ff, ch_in;
   logic [7:0]        at_ff, at_in;
   logic signed [7:0] ca_ff, ca_in;
   logic signed [7:0] ra_ff, ra_in;

   // Cursor
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   // Linear cell addresses and sweep pointers
   logic [AW-1:0] cbase_ff, cbase_in;
   logic [AW-1:0] tbase_ff, tbase_in;
   logic [AW-1:0] bbase_ff, bbase_in;
   logic [AW-1:0] rbase_ff, rbase_in;
   logic [AW-1:0] dst_ff, dst_in;
   logic [AW-1:0] src_ff, src_in;
   logic [AW-1:0] end_ff, end_in;
   logic          back_ff, back_in;
   logic [15:0]   fill_ff, fill_in;
   logic [CW-1:0] scol_ff, scol_in;
   logic [TW-1:0] tcnt_ff, tcnt_in;
   logic          tdef_ff, tdef_in;
   logic [CW-1:0] xcol_ff, xcol_in;
   logic [15:0]   rd_ff, rd_in;

   // Result register
   logic          rv_ff, rv_in;
   logic [6:0]    rcol_ff, rcol_in;
   logic [4:0]    rrow_ff, rrow_in;
   logic          rpw_ff, rpw_in;
   logic [15:0]   rcell_ff, rcell_in;

   // Stores
   logic [15:0] cell_mem [CELLS];
   logic        tab_mem [CELLS];
   logic [15:0] cell_q_ff;
   logic        tab_q_ff;
   logic          cell_we, tab_we, tab_wdata;
   logic [AW-1:0] cell_waddr, tab_waddr;
   logic [15:0]   cell_wdata;

   logic accept, cfg_wr;

   assign accept  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE) || (rv_ff && rsp_stall);
   assign cfg_wr  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   assign rsp_valid        = rv_ff;
   assign rsp_cursor_col   = rcol_ff;
   assign rsp_cursor_row   = rrow_ff;
   assign rsp_pending_wrap = rpw_ff;
   assign rsp_read_cell    = rcell_ff;

   // Effective scroll margins: bottom is limited to the last row, and a top that is not
   // above the bottom selects the whole screen.
   logic [6:0]    bot_w, bb_w, tt_w;
   logic [RW-1:0] t_eff, b_eff;

   always_comb begin
      bot_w = 7'(bot_ff);
      tt_w  = 7'(top_ff);
      bb_w  = (bot_w > 7'(ROWS - 1)) ? 7'(ROWS - 1) : bot_w;
      if (tt_w >= bb_w) begin
         t_eff = '0;
         b_eff = RW'(ROWS - 1);
      end else begin
         t_eff = tt_w[RW-1:0];
         b_eff = bb_w[RW-1:0];
      end
   end

   // Decisions shared by the next state and output logic
   logic          pend, row_lt_b, row_gt_t, tab_skip, rd_ok, erase_go;
   logic          cp_last, blk_last, sw_last, tab_last;
   logic [AW-1:0] pos, pos_next, erase_from, erase_to;

   assign pend     = (col_ff == CW'(COLS));
   assign row_lt_b = (row_ff < b_eff);
   assign row_gt_t = (row_ff > t_eff);
   assign tab_skip = (col_ff >= CW'(COLS - 1));
   assign rd_ok    = !ca_ff[7] && !ra_ff[7] && (ca_ff < 8'(COLS)) && (ra_ff < 8'(ROWS));
   assign pos      = cbase_ff + AW'(col_ff);
   assign pos_next = (pos + AW'(1) > AW'(CELLS)) ? AW'(CELLS) : pos + AW'(1);
   assign cp_last  = (dst_ff == end_ff);
   assign blk_last = (dst_ff + AW'(1) == end_ff);
   assign sw_last  = (dst_ff == AW'(CELLS - 1));
   assign tab_last = (xcol_ff == CW'(COLS - 1));

   always_comb begin
      erase_from = '0;
      erase_to   = '0;
      case (op_ff)
         OP_ERASE_SOS: begin
            erase_from = '0;
            erase_to   = pos_next;
         end
         OP_ERASE_EOS: begin
            erase_from = pos;
            erase_to   = AW'(CELLS);
         end
         OP_ERASE_SOL: begin
            erase_from = cbase_ff;
            erase_to   = pos_next;
         end
         OP_ERASE_EOL: begin
            erase_from = pos;
            erase_to   = cbase_ff + AW'(COLS);
         end
         OP_ERASE_LINE: begin
            if (!ra_ff[7] && (ra_ff < 8'(ROWS))) begin
               erase_from = rbase_ff;
               erase_to   = rbase_ff + AW'(COLS);
            end
         end
         default: begin
            erase_from = '0;
            erase_to   = '0;
         end
      endcase
   end
   assign erase_go = (erase_from < erase_to);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  if (sw_last) state_in = ST_IDLE;
         ST_IDLE:   if (accept) state_in = ST_PREP;
         ST_PREP:   state_in = ST_EXEC;
         ST_EXEC: begin
            state_in = ST_DONE;
            case (op_ff)
               OP_PUT:        if (pend && !row_lt_b) state_in = ST_CP_RD;
               OP_NEWLINE:    if (!row_lt_b) state_in = ST_CP_RD;
               OP_DOWN:       if (!row_lt_b) state_in = ST_CP_RD;
               OP_UP:         if (!row_gt_t) state_in = ST_CP_RD;
               OP_SCROLLFWD:  state_in = ST_CP_RD;
               OP_SCROLLBACK: state_in = ST_CP_RD;
               OP_TAB:        if (!tab_skip) state_in = ST_TAB_RD;
               OP_CLRALLTABS: state_in = ST_TAB_SWEEP;
               OP_DEFTABS:    state_in = ST_TAB_SWEEP;
               OP_FILL:       state_in = ST_BLANK;
               OP_CLEAR:      state_in = ST_BLANK;
               OP_ERASE_SOS, OP_ERASE_EOS, OP_ERASE_SOL, OP_ERASE_EOL, OP_ERASE_LINE:
                  if (erase_go) state_in = ST_BLANK;
               OP_READ:       if (rd_ok) state_in = ST_RD_ISSUE;
               default:       state_in = ST_DONE;
            endcase
         end
         ST_CP_RD:     state_in = ST_CP_WR;
         ST_CP_WR:     state_in = cp_last ? ST_BLANK : ST_CP_RD;
         ST_BLANK: begin
            if (blk_last) state_in = (aft_ff == AFT_PUT) ? ST_PUT_WR : ST_DONE;
         end
         ST_TAB_SWEEP: if (sw_last) state_in = ST_DONE;
         ST_TAB_RD:    state_in = ST_TAB_CHK;
         ST_TAB_CHK:   if (tab_q_ff || tab_last) state_in = ST_DONE; else state_in = ST_TAB_RD;
         ST_RD_ISSUE:  state_in = ST_RD_TAKE;
         ST_RD_TAKE:   state_in = ST_DONE;
         ST_PUT_WR:    state_in = ST_DONE;
         ST_DONE:      state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Arithmetic for relative and absolute moves
   logic signed [9:0] colsum;
   logic signed [8:0] rowsum, spos_row, t_s, b_s, lo_s, hi_s;
   logic [CW-1:0]     mv_col, sp_col;
   logic [RW-1:0]     mv_row, sp_row, home_row, orow;
   logic [7:0]        put_attr;

   always_comb begin
      t_s    = $signed(9'(t_eff));
      b_s    = $signed(9'(b_eff));
      colsum = $signed(10'(col_ff)) + 10'(ca_ff)
               - (((ca_ff != 8'sd0) || (ra_ff != 8'sd0)) && pend ? 10'sd1 : 10'sd0);
      if (colsum < 10'sd0)                    mv_col = '0;
      else if (colsum > $signed(10'(COLS - 1))) mv_col = CW'(COLS - 1);
      else                                    mv_col = colsum[CW-1:0];
      rowsum = $signed(9'(row_ff)) + 9'(ra_ff);
      if (rowsum < t_s)      mv_row = t_eff;
      else if (rowsum > b_s) mv_row = b_eff;
      else                   mv_row = rowsum[RW-1:0];

      if (ca_ff < 8'sd0)                         sp_col = '0;
      else if ($signed(10'(ca_ff)) > $signed(10'(COLS - 1))) sp_col = CW'(COLS - 1);
      else                                       sp_col = ca_ff[CW-1:0];
      spos_row = origin_ff ? 9'(ra_ff) + t_s : 9'(ra_ff);
      lo_s     = origin_ff ? t_s : 9'sd0;
      hi_s     = origin_ff ? b_s : $signed(9'(ROWS - 1));
      if (spos_row < lo_s)      sp_row = lo_s[RW-1:0];
      else if (spos_row > hi_s) sp_row = hi_s[RW-1:0];
      else                      sp_row = spos_row[RW-1:0];

      home_row = origin_ff ? t_eff : '0;
      put_attr = (forced_ff != 8'd0) ? forced_ff : at_ff;
      if (!origin_ff)          orow = row_ff;
      else if (row_ff < t_eff) orow = '0;
      else                     orow = row_ff - t_eff;
   end

   // Datapath and store controls
   always_comb begin
      top_in    = top_ff;
      bot_in    = bot_ff;
      origin_in = origin_ff;
      forced_in = forced_ff;
      aft_in    = aft_ff;
      op_in     = op_ff;
      ch_in     = ch_ff;
      at_in     = at_ff;
      ca_in     = ca_ff;
      ra_in     = ra_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      cbase_in  = cbase_ff;
      tbase_in  = tbase_ff;
      bbase_in  = bbase_ff;
      rbase_in  = rbase_ff;
      dst_in    = dst_ff;
      src_in    = src_ff;
      end_in    = end_ff;
      back_in   = back_ff;
      fill_in   = fill_ff;
      scol_in   = scol_ff;
      tcnt_in   = tcnt_ff;
      tdef_in   = tdef_ff;
      xcol_in   = xcol_ff;
      rd_in     = rd_ff;
      rv_in     = rv_ff && rsp_stall;
      rcol_in   = rcol_ff;
      rrow_in   = rrow_ff;
      rpw_in    = rpw_ff;
      rcell_in  = rcell_ff;
      cell_we    = 1'b0;
      cell_waddr = dst_ff;
      cell_wdata = fill_ff;
      tab_we     = 1'b0;
      tab_waddr  = dst_ff;
      tab_wdata  = 1'b0;

      if (cfg_wr) begin
         case (csr_paddr[3:2])
            REG_TOP_MARGIN:    top_in    = csr_pwdata[4:0];
            REG_BOTTOM_MARGIN: bot_in    = csr_pwdata[4:0];
            REG_ORIGIN:        origin_in = csr_pwdata[0];
            REG_FORCED_ATTR:   forced_in = csr_pwdata[7:0];
            default:           top_in    = top_ff;
         endcase
      end

      case (state_ff)
         ST_CLEAR, ST_TAB_SWEEP: begin
            cell_we    = (state_ff == ST_CLEAR);
            cell_wdata = BLANK_CELL;
            tab_we     = 1'b1;
            tab_wdata  = ((state_ff == ST_CLEAR) || tdef_ff) && (tcnt_ff == '0);
            dst_in     = dst_ff + AW'(1);
            if (scol_ff == CW'(COLS - 1)) begin
               scol_in = '0;
               tcnt_in = '0;
            end else begin
               scol_in = scol_ff + CW'(1);
               tcnt_in = (tcnt_ff == TW'(TAB_SPACING - 1)) ? '0 : tcnt_ff + TW'(1);
            end
         end
         ST_IDLE: begin
            if (accept) begin
               op_in = req_opcode;
               ch_in = req_char_code;
               at_in = req_attr_byte;
               ca_in = req_col_arg;
               ra_in = req_row_arg;
               rd_in = '0;
            end
         end
         ST_PREP: begin
            cbase_in = AW'(row_ff * COLS);
            tbase_in = AW'(t_eff * COLS);
            bbase_in = AW'(b_eff * COLS);
            rbase_in = AW'(ra_ff[RW-1:0] * COLS);
         end
         ST_EXEC: begin
            // Defaults for a forward scroll, used by the scrolling cases below
            dst_in  = tbase_ff;
            src_in  = tbase_ff + AW'(COLS);
            end_in  = bbase_ff - AW'(1);
            back_in = 1'b0;
            aft_in  = AFT_DONE;
            case (op_ff)
               OP_PUT: begin
                  cell_wdata = {put_attr, ch_ff};
                  if (!pend) begin
                     cell_we    = 1'b1;
                     cell_waddr = pos;
                     col_in     = col_ff + CW'(1);
                  end else if (row_lt_b) begin
                     cell_we    = 1'b1;
                     cell_waddr = cbase_ff + AW'(COLS);
                     row_in     = row_ff + RW'(1);
                     col_in     = CW'(1);
                  end else begin
                     // Wrap at the bottom margin: scroll first, then write in PUT_WR
                     row_in = b_eff;
                     col_in = '0;
                     aft_in = AFT_PUT;
                  end
               end
               OP_NEWLINE, OP_DOWN: begin
                  col_in = (op_ff == OP_NEWLINE || !row_lt_b) ? '0 : col_ff;
                  if (row_lt_b) row_in = row_ff + RW'(1);
               end
               OP_UP: begin
                  if (row_gt_t) begin
                     row_in = row_ff - RW'(1);
                  end else begin
                     col_in  = '0;
                     dst_in  = bbase_ff + AW'(COLS - 1);
                     src_in  = bbase_ff - AW'(1);
                     end_in  = tbase_ff + AW'(COLS);
                     back_in = 1'b1;
                  end
               end
               OP_SCROLLFWD: col_in = '0;
               OP_SCROLLBACK: begin
                  col_in  = '0;
                  dst_in  = bbase_ff + AW'(COLS - 1);
                  src_in  = bbase_ff - AW'(1);
                  end_in  = tbase_ff + AW'(COLS);
                  back_in = 1'b1;
               end
               OP_TAB: begin
                  if (pend) col_in = CW'(COLS - 1);
                  xcol_in = col_ff + CW'(1);
                  src_in  = pos + AW'(1);
               end
               OP_SETTAB, OP_CLRTAB: begin
                  tab_we    = 1'b1;
                  tab_waddr = pend ? cbase_ff + AW'(COLS - 1) : pos;
                  tab_wdata = (op_ff == OP_SETTAB);
               end
               OP_CLRALLTABS, OP_DEFTABS: begin
                  dst_in  = '0;
                  scol_in = '0;
                  tcnt_in = '0;
                  tdef_in = (op_ff == OP_DEFTABS);
               end
               OP_MOVEREL: begin
                  col_in = mv_col;
                  row_in = mv_row;
               end
               OP_SETPOS: begin
                  col_in = sp_col;
                  row_in = sp_row;
               end
               OP_FILL, OP_CLEAR: begin
                  dst_in  = '0;
                  end_in  = AW'(CELLS);
                  fill_in = (op_ff == OP_FILL) ? {FILL_ATTR, ch_ff} : BLANK_CELL;
                  aft_in  = AFT_HOME;
               end
               OP_ERASE_SOS, OP_ERASE_EOS, OP_ERASE_SOL, OP_ERASE_EOL, OP_ERASE_LINE: begin
                  dst_in  = erase_from;
                  end_in  = erase_to;
                  fill_in = BLANK_CELL;
               end
               OP_READ: src_in = rbase_ff + AW'(ca_ff[6:0]);
               default: col_in = col_ff;
            endcase
         end
         ST_CP_WR: begin
            cell_we    = 1'b1;
            cell_wdata = cell_q_ff;
            if (cp_last) begin
               dst_in  = back_ff ? tbase_ff : bbase_ff;
               end_in  = (back_ff ? tbase_ff : bbase_ff) + AW'(COLS);
               fill_in = BLANK_CELL;
            end else if (back_ff) begin
               dst_in = dst_ff - AW'(1);
               src_in = src_ff - AW'(1);
            end else begin
               dst_in = dst_ff + AW'(1);
               src_in = src_ff + AW'(1);
            end
         end
         ST_BLANK: begin
            cell_we = 1'b1;
            dst_in  = dst_ff + AW'(1);
            if (blk_last && aft_ff == AFT_HOME) begin
               col_in = '0;
               row_in = home_row;
            end
         end
         ST_TAB_CHK: begin
            if (tab_q_ff) begin
               col_in = xcol_ff;
            end else if (tab_last) begin
               col_in = CW'(COLS - 1);
            end else begin
               xcol_in = xcol_ff + CW'(1);
               src_in  = src_ff + AW'(1);
            end
         end
         ST_RD_TAKE: rd_in = cell_q_ff;
         ST_PUT_WR: begin
            cell_we    = 1'b1;
            cell_waddr = bbase_ff;
            cell_wdata = {put_attr, ch_ff};
            col_in     = CW'(1);
         end
         ST_DONE: begin
            rv_in    = 1'b1;
            rcol_in  = 7'(pend ? CW'(COLS - 1) : col_ff);
            rrow_in  = 5'(orow);
            rpw_in   = pend;
            rcell_in = rd_ff;
         end
         default: rd_in = rd_ff;
      endcase
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_TOP_MARGIN:    csr_prdata = 32'(top_ff);
         REG_BOTTOM_MARGIN: csr_prdata = 32'(bot_ff);
         REG_ORIGIN:        csr_prdata = 32'(origin_ff);
         REG_FORCED_ATTR:   csr_prdata = 32'(forced_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // Stores: one write and one registered read per cycle each
   always_ff @(posedge clock) begin
      if (cell_we) cell_mem[cell_waddr[IW-1:0]] <= cell_wdata;
      if (tab_we)  tab_mem[tab_waddr[IW-1:0]]   <= tab_wdata;
      cell_q_ff <= cell_mem[src_ff[IW-1:0]];
      tab_q_ff  <= tab_mem[src_ff[IW-1:0]];
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         top_ff    <= 5'd0;
         bot_ff    <= 5'd24;
         origin_ff <= 1'b0;
         forced_ff <= 8'd0;
         col_ff    <= '0;
         row_ff    <= '0;
         rv_ff     <= 1'b0;
         dst_ff    <= '0;
         scol_ff   <= '0;
         tcnt_ff   <= '0;
         aft_ff    <= AFT_DONE;
      end else begin
         state_ff  <= state_in;
         top_ff    <= top_in;
         bot_ff    <= bot_in;
         origin_ff <= origin_in;
         forced_ff <= forced_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         rv_ff     <= rv_in;
         dst_ff    <= dst_in;
         scol_ff   <= scol_in;
         tcnt_ff   <= tcnt_in;
         aft_ff    <= aft_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      ch_ff    <= ch_in;
      at_ff    <= at_in;
      ca_ff    <= ca_in;
      ra_ff    <= ra_in;
      cbase_ff <= cbase_in;
      tbase_ff <= tbase_in;
      bbase_ff <= bbase_in;
      rbase_ff <= rbase_in;
      src_ff   <= src_in;
      end_ff   <= end_in;
      back_ff  <= back_in;
      fill_ff  <= fill_in;
      tdef_ff  <= tdef_in;
      xcol_ff  <= xcol_in;
      rd_ff    <= rd_in;
      rcol_ff  <= rcol_in;
      rrow_ff  <= rrow_in;
      rpw_ff   <= rpw_in;
      rcell_ff <= rcell_in;
   end

   // The cursor column never passes the pending-wrap position
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= CW'(COLS))
      else $error("cursor column beyond pending wrap");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      row_ff <= RW'(ROWS - 1))
      else $error("cursor row beyond screen");

   // An accepted word always leaves the idle state
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_PREP))
      else $error("accepted word not taken into preparation");

   // A new result only ever comes from the done step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rv_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the done step");

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the text screen cursor engine, with its own screen predictor.
module tb_top
   import tscr_pkg::*;
();

   localparam int NCOLS  = 80;
   localparam int NROWS  = 25;
   localparam int NCELLS = NCOLS * NROWS;
   localparam int TABSP  = 6;

   // One result word as the block reports it.
   typedef struct packed {
      logic [6:0]  col;
      logic [4:0]  row;
      logic        wrap;
      logic [15:0] rd_cell;
   } cursor_word_type;

   // One row of the directed table; check_now marks a result typed in by hand.
   typedef struct {
      logic [4:0]      op;
      logic [7:0]      ch;
      logic [7:0]      at;
      logic [7:0]      ca;
      logic [7:0]      ra;
      bit              check_now;
      cursor_word_type want;
   } stim_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [4:0]        req_opcode = '0;
   logic [7:0]        req_char_code = '0;
   logic [7:0]        req_attr_byte = '0;
   logic signed [7:0] req_col_arg = '0;
   logic signed [7:0] req_row_arg = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b1;
   logic [6:0]        rsp_cursor_col;
   logic [4:0]        rsp_cursor_row;
   logic              rsp_pending_wrap;
   logic [15:0]       rsp_read_cell;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [3:0]        csr_paddr = '0;
   logic [31:0]       csr_pwdata = '0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   text_screen_cursor_engine u_dut (.*);

   always #5 clock = ~clock;

   // Predictor state: a private copy of the screen, tab stops, cursor and registers.
   logic [15:0] scr_cells [NCELLS];
   bit          scr_tabs  [NCELLS];
   int          pos_col, pos_row;
   int          reg_top, reg_bottom, reg_origin, reg_forced;

   cursor_word_type expected_words [$];
   int              err_count = 0;
   int              words_seen = 0;

   task automatic report(input string what, input int got, input int want);
      $display("mismatch on result %0d: %s got %0h want %0h", words_seen, what, got, want);
      err_count++;
   endtask

   function automatic int clampv(input int v, input int lo, input int hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic void eff_margins(output int t, output int b);
      b = reg_bottom > NROWS - 1 ? NROWS - 1 : reg_bottom;
      t = reg_top;
      if (t >= b) begin
         t = 0;
         b = NROWS - 1;
      end
   endfunction

   function automatic void blank_cells(input int lo, input int hi);
      if (lo < 0) lo = 0;
      if (hi > NCELLS) hi = NCELLS;
      for (int i = lo; i < hi; i++) scr_cells[i] = BLANK_CELL;
   endfunction

   function automatic void load_default_tabs();
      for (int i = 0; i < NCELLS; i++) scr_tabs[i] = (i % NCOLS) % TABSP == 0;
   endfunction

   // Scrolls the region one line; up moves text towards the top margin.
   function automatic void scroll_region(input bit up);
      int t, b;
      eff_margins(t, b);
      if (up) begin
         for (int i = t * NCOLS; i < b * NCOLS; i++) scr_cells[i] = scr_cells[i + NCOLS];
         blank_cells(b * NCOLS, (b + 1) * NCOLS);
      end else begin
         for (int i = (b + 1) * NCOLS - 1; i >= (t + 1) * NCOLS; i--)
            scr_cells[i] = scr_cells[i - NCOLS];
         blank_cells(t * NCOLS, (t + 1) * NCOLS);
      end
      pos_col = 0;
   endfunction

   function automatic void place_cursor(input int c, input int r);
      int t, b, lo, hi;
      lo = 0;
      hi = NROWS - 1;
      if (reg_origin != 0) begin
         eff_margins(t, b);
         r += t;
         lo = t;
         hi = b;
      end
      pos_col = clampv(c, 0, NCOLS - 1);
      pos_row = clampv(r, lo, hi);
   endfunction

   function automatic void screen_reset();
      blank_cells(0, NCELLS);
      load_default_tabs();
      pos_col = 0;
      pos_row = 0;
      reg_top = 0;
      reg_bottom = 24;
      reg_origin = 0;
      reg_forced = 0;
   endfunction

   // Applies one word to the predicted screen and returns the result it must give.
   function automatic cursor_word_type screen_step(input logic [4:0] op, input logic [7:0] ch,
                                                   input logic [7:0] at_in,
                                                   input logic signed [7:0] ca_in,
                                                   input logic signed [7:0] ra_in);
      cursor_word_type w;
      int t, b, p, tc, x, ca, ra, orow;
      logic [7:0] at;
      logic [15:0] rd;
      at = at_in;
      ca = ca_in;
      ra = ra_in;
      rd = '0;
      eff_margins(t, b);
      p  = pos_row * NCOLS + pos_col;
      tc = pos_col > NCOLS - 1 ? NCOLS - 1 : pos_col;
      case (op)
         OP_PUT: begin
            if (reg_forced != 0) at = reg_forced[7:0];
            if (pos_col >= NCOLS) begin
               // A wrapped put at the bottom margin scrolls before writing.
               if (pos_row < b) pos_row++;
               else begin
                  scroll_region(1'b1);
                  pos_row = b;
               end
               scr_cells[pos_row * NCOLS] = {at, ch};
               pos_col = 1;
            end else begin
               scr_cells[p] = {at, ch};
               pos_col++;
            end
         end
         OP_NEWLINE: begin
            if (pos_row < b) begin
               pos_row++;
               pos_col = 0;
            end else scroll_region(1'b1);
         end
         OP_TAB: begin
            if (pos_col != NCOLS - 1) begin
               for (x = pos_col + 1; x < NCOLS; x++)
                  if (scr_tabs[pos_row * NCOLS + x]) break;
               pos_col = x < NCOLS ? x : NCOLS - 1;
            end
         end
         OP_SETTAB:     scr_tabs[pos_row * NCOLS + tc] = 1'b1;
         OP_CLRTAB:     scr_tabs[pos_row * NCOLS + tc] = 1'b0;
         OP_CLRALLTABS: for (int i = 0; i < NCELLS; i++) scr_tabs[i] = 1'b0;
         OP_DOWN: begin
            if (pos_row < b) pos_row++;
            else scroll_region(1'b1);
         end
         OP_UP: begin
            if (pos_row > t) pos_row--;
            else scroll_region(1'b0);
         end
         OP_MOVEREL: begin
            if ((ca != 0 || ra != 0) && pos_col == NCOLS) ca--;
            pos_col = clampv(pos_col + ca, 0, NCOLS - 1);
            pos_row = clampv(pos_row + ra, t, b);
         end
         OP_SETPOS:     place_cursor(ca, ra);
         OP_SCROLLFWD:  scroll_region(1'b1);
         OP_SCROLLBACK: scroll_region(1'b0);
         OP_FILL: begin
            for (int i = 0; i < NCELLS; i++) scr_cells[i] = {FILL_ATTR, ch};
            place_cursor(0, 0);
         end
         OP_CLEAR: begin
            blank_cells(0, NCELLS);
            place_cursor(0, 0);
         end
         OP_ERASE_SOS:  blank_cells(0, p + 1);
         OP_ERASE_EOS:  blank_cells(p, NCELLS);
         OP_ERASE_SOL:  blank_cells(pos_row * NCOLS, p + 1);
         OP_ERASE_EOL:  blank_cells(p, (pos_row + 1) * NCOLS);
         OP_ERASE_LINE: if (ra >= 0 && ra < NROWS) blank_cells(ra * NCOLS, (ra + 1) * NCOLS);
         OP_READ: begin
            if (ca >= 0 && ca < NCOLS && ra >= 0 && ra < NROWS) rd = scr_cells[ra * NCOLS + ca];
         end
         OP_DEFTABS:    load_default_tabs();
         default: ;
      endcase
      orow = pos_row;
      if (reg_origin != 0) begin
         eff_margins(t, b);
         orow -= t;
         if (orow < 0) orow = 0;
      end
      w.col     = 7'(pos_col > NCOLS - 1 ? NCOLS - 1 : pos_col);
      w.row     = 5'(orow);
      w.wrap    = pos_col == NCOLS;
      w.rd_cell = rd;
      return w;
   endfunction

   // Register write over the control port; only used while the block is idle.
   task automatic csr_write(input logic [1:0] idx, input int val);
      @(posedge clock);
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr  <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_TOP_MARGIN:    reg_top    = val & 31;
         REG_BOTTOM_MARGIN: reg_bottom = val & 31;
         REG_ORIGIN:        reg_origin = val & 1;
         default:           reg_forced = val & 255;
      endcase
   endtask

   // Presents one word, after a random gap if asked, and predicts its result on acceptance.
   task automatic send_word(input logic [4:0] op, input logic [7:0] ch, input logic [7:0] at,
                            input logic [7:0] ca, input logic [7:0] ra,
                            input bit gaps, output cursor_word_type pred);
      int gap;
      gap = gaps ? $urandom_range(0, 13) : 0;
      // The block stalls while it prepares and executes an accepted word, so waiting on the clock
      // first keeps the lowering of valid apart from the next raise at no cost.
      @(posedge clock);
      repeat (gap) @(posedge clock);
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_char_code <= ch;
      req_attr_byte <= at;
      req_col_arg   <= ca;
      req_row_arg   <= ra;
      do @(posedge clock); while (req_stall);
      pred = screen_step(op, ch, at, ca, ra);
      expected_words.push_back(pred);
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Result side: random stall lengths, with long stretches of none at all.
   bit stall_free = 1'b0;
   initial begin
      int hold;
      @(negedge reset);
      forever begin
         hold = stall_free ? 0 : $urandom_range(0, 13);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
      end
   end

   // Every accepted result is compared with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         cursor_word_type w;
         if (expected_words.size() == 0) begin
            report("unexpected result word", 1, 0);
         end else begin
            w = expected_words.pop_front();
            if (rsp_cursor_col != w.col) report("cursor_col", rsp_cursor_col, w.col);
            if (rsp_cursor_row != w.row) report("cursor_row", rsp_cursor_row, w.row);
            if (rsp_pending_wrap != w.wrap) report("pending_wrap", rsp_pending_wrap, w.wrap);
            if (rsp_read_cell != w.rd_cell) report("read_cell", rsp_read_cell, w.rd_cell);
         end
         words_seen++;
      end
   end

   // Directed table: extremes, every opcode and the named corner cases.
   stim_row_type dir_rows [] = '{
      '{OP_READ,       8'h00, 8'h00, 8'd0,   8'd0,   1, '{7'd0,  5'd0,  1'b0, 16'h0F20}},
      '{OP_READ,       8'h00, 8'h00, 8'h80,  8'h7F,  1, '{7'd0,  5'd0,  1'b0, 16'h0000}},
      '{OP_PUT,        8'hFF, 8'hFF, 8'd0,   8'd0,   1, '{7'd1,  5'd0,  1'b0, 16'h0000}},
      '{OP_READ,       8'h00, 8'h00, 8'd0,   8'd0,   1, '{7'd1,  5'd0,  1'b0, 16'hFFFF}},
      '{OP_SETPOS,     8'h00, 8'h00, 8'h7F,  8'h7F,  1, '{7'd79, 5'd24, 1'b0, 16'h0000}},
      '{OP_PUT,        8'h41, 8'h12, 8'd0,   8'd0,   1, '{7'd79, 5'd24, 1'b1, 16'h0000}},
      '{OP_SETTAB,     8'h00, 8'h00, 8'd0,   8'd0,   0, '{default: '0}},
      '{OP_ERASE_EOS,  8'h00, 8'h00, 8'd0,   8'd0,   0, '{default: '0}},
      '{OP_ERASE_SOS,  8'h00, 8'h00, 8'd0,   8'd0,   0, '{default: '0}},
      '{OP_PUT,        8'h42, 8'h34, 8'd0,   8'd0,   1, '{7'd1,  5'd24, 1'b0, 16'h0000}},
      '{OP_READ,       8'h00, 8'h00, 8'd0,   8'd24,  0, '{default: '0}},
      '{OP_MOVEREL,    8'h00, 8'h00, 8'h80,  8'h80,  1, '{7'd0,  5'd0,  1'b0, 16'h0000}},
      '{OP_TAB,        8'h00, 8'h00, 8'd0,   8'd0,   1, '{7'd6,  5'd0,  1'b0, 16'h0000}},
      '{OP_CLRTAB,     8'h00, 8'h00, 8'd0,   8'd0,   0, '{default: '0}},
      '{OP_CLRALLTABS, 8'h00, 8'h00, 8'd0,   8'd0,   0, '{default: '0}},
      '{OP_TAB,        8'h00, 8'h00, 8'd0,   8'd0,   1, '{7'd79, 5'd0,  1'b0, 16'h0000}},
      '{OP_DEFTABS,    8'h00, 8'h00, 8'd0,   8'd0,   0, '{default: '0}},
      '{OP_UP,         8'h00, 8'h00, 8'd0,   8'd0,   0, '{default: '0}},
      '{OP_NEWLINE,    8'h00, 8'h00, 8'd0,   8'd0,   0, '{default: '0}},
      '{OP_DOWN,       8'h00, 8'h00, 8'd0,   8'd0,   0, '{default: '0}},
      '{OP_SCROLLFWD,  8'h00, 8'h00, 8'd0,   8'd0,   0, '{default: '0}},
      '{OP_SCROLLBACK, 8'h00, 8'h00, 8'd0,   8'd0,   0, '{default: '0}},
      '{OP_ERASE_SOL,  8'h00, 8'h00, 8'd0,   8'd0,   0, '{default: '0}},
      '{OP_ERASE_EOL,  8'h00, 8'h00, 8'd0,   8'd0,   0, '{default: '0}},
      '{OP_ERASE_LINE, 8'h00, 8'h00, 8'd0,   8'hFF,  0, '{default: '0}},
      '{OP_FILL,       8'hAA, 8'h00, 8'd0,   8'd0,   1, '{7'd0,  5'd0,  1'b0, 16'h0000}},
      '{5'd31,         8'h00, 8'h00, 8'd0,   8'd0,   0, '{default: '0}},
      '{OP_CLEAR,      8'h00, 8'h00, 8'd0,   8'd0,   1, '{7'd0,  5'd0,  1'b0, 16'h0000}}
   };

   // Random word, biased towards text and cursor traffic; the costly sweeps are rarer.
   task automatic send_random_word();
      cursor_word_type pred;
      logic [4:0] op;
      logic [7:0] ca, ra;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40)      op = OP_PUT;
      else if (pick < 48) op = OP_READ;
      else if (pick < 92) op = 5'($urandom_range(1, 9));
      else if (pick < 97) op = 5'($urandom_range(10, 20));
      else                op = 5'($urandom_range(0, 31));
      // Arguments mostly on screen, sometimes anywhere in the signed range.
      if ($urandom_range(0, 3) == 0) begin
         ca = 8'($urandom);
         ra = 8'($urandom);
      end else if (op == OP_MOVEREL) begin
         ca = 8'($urandom_range(0, 20) - 10);
         ra = 8'($urandom_range(0, 6) - 3);
      end else begin
         ca = 8'($urandom_range(0, NCOLS - 1));
         ra = 8'($urandom_range(0, NROWS - 1));
      end
      send_word(op, 8'($urandom), 8'($urandom), ca, ra, 1'b1, pred);
   endtask

   initial begin
      cursor_word_type pred;
      int tops [4];
      int bottoms [4];
      tops    = '{0, 3, 24, 10};
      bottoms = '{24, 20, 31, 10};
      screen_reset();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The directed table runs with the reset register values.
      foreach (dir_rows[i]) begin
         send_word(dir_rows[i].op, dir_rows[i].ch, dir_rows[i].at, dir_rows[i].ca,
                   dir_rows[i].ra, 1'b0, pred);
         if (dir_rows[i].check_now && pred != dir_rows[i].want)
            report("table row", i, 0);
      end
      wait_drained();

      // Random phases, each under its own register setting, extremes included.
      for (int ph = 0; ph < 8; ph++) begin
         csr_write(REG_TOP_MARGIN, ph < 4 ? tops[ph] : $urandom_range(0, 31));
         csr_write(REG_BOTTOM_MARGIN, ph < 4 ? bottoms[ph] : $urandom_range(0, 31));
         csr_write(REG_ORIGIN, ph % 2);
         csr_write(REG_FORCED_ATTR, ph == 2 ? 255 : (ph == 5 ? $urandom_range(1, 254) : 0));
         stall_free = ph == 6;
         for (int n = 0; n < 125; n++) begin
            send_random_word();
            // The sender holds off once until every expected result is back.
            if (ph == 3 && n == 60) while (expected_words.size() != 0) @(posedge clock);
         end
         wait_drained();
      end

      if (err_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   // Generous cap: the clearing pass and about a thousand words, each allowed a full-screen
   // scroll with the longest gaps and stalls, with ample room to spare.
   initial begin
      #250ms;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/tscr_pkg.sv
hw/rtl/text_screen_cursor_engine.sv
dv/tb_top.sv
